/* design/ivec_pkg.sv */
// Shared types, constants and codes for the interrupt vector allocator.
// Used by ivec_controller, ivec_datapath and irq_vector_allocator; no dependencies.
package ivec_pkg;

   // Sizes of the vector tables and of the request fields.
   localparam int NUM_CPUS    = 4;
   localparam int NUM_VECTORS = 256;
   localparam int CPU_W       = 2;
   localparam int VEC_W       = 8;
   localparam int MODE_W      = 3;
   localparam int CNT_W       = 9;
   localparam int MARK_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int MEM_DEPTH   = NUM_CPUS * NUM_VECTORS;
   localparam int ADDR_W      = $clog2(MEM_DEPTH);
   localparam int PTR_W       = VEC_W + 1;

   // Bit positions of the two marks in a table entry.
   localparam int RSV_BIT = 0;
   localparam int CON_BIT = 1;

   // Request codes.
   localparam logic [MODE_W-1:0] MODE_RESERVE    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UNRESERVE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CONNECT    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DISCONNECT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LEAST      = 3'd4;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_VECTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_VECTOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CPU_ENABLE   = 2'd2;
   localparam logic [VEC_W-1:0]     FIRST_VECTOR_RST = 8'd32;
   localparam logic [VEC_W-1:0]     LAST_VECTOR_RST  = 8'd254;
   localparam logic [NUM_CPUS-1:0]  CPU_ENABLE_RST   = 4'hF;

   // One request item.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CPU_W-1:0]  cpu_index;
      logic              any_vector;
      logic [VEC_W-1:0]  vector;
   } ivec_req_type;

   // One result item.
   typedef struct packed {
      logic             ok;
      logic [CPU_W-1:0] cpu_out;
      logic [VEC_W-1:0] vector_out;
   } ivec_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic sel_req_cpu;
      logic sel_best;
      logic read_named;
      logic scan_start;
      logic scan_step;
      logic commit;
      logic fail;
   } ivec_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic              clear_last;
      logic [MODE_W-1:0] mode;
      logic              any_vector;
      logic              cpu_valid;
      logic              vec_valid;
      logic              best_found;
      logic              rd_valid;
      logic              hit;
      logic              op_ok;
      logic              out_free;
   } ivec_sts_type;

endpackage

/* design/ivec_datapath.sv */
// Datapath of the interrupt vector allocator: configuration registers, mark memory,
// reservation counters, vector scan and result register. Depends on ivec_pkg.
module ivec_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ivec_pkg::ivec_cmd_type            cmd,
   output ivec_pkg::ivec_sts_type            sts,
   input  ivec_pkg::ivec_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ivec_pkg::ivec_rsp_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ivec_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ivec_pkg::CSR_DATA_W-1:0]   csr_data
);

   // Configuration registers.
   logic [ivec_pkg::VEC_W-1:0]    first_vector_ff;
   logic [ivec_pkg::VEC_W-1:0]    last_vector_ff;
   logic [ivec_pkg::NUM_CPUS-1:0] cpu_enable_ff;

   // Request and working registers.
   ivec_pkg::ivec_req_type        req_ff;
   logic [ivec_pkg::CPU_W-1:0]    cpu_sel_ff, cpu_sel_in;
   logic [ivec_pkg::CNT_W-1:0]    reserved_count_ff [ivec_pkg::NUM_CPUS];
   logic [ivec_pkg::ADDR_W-1:0]   clear_ptr_ff;
   logic [ivec_pkg::PTR_W-1:0]    scan_ptr_ff, scan_ptr_in;
   logic [ivec_pkg::VEC_W-1:0]    rd_vec_ff, rd_vec_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [ivec_pkg::MARK_W-1:0]   mark_q_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   ivec_pkg::ivec_rsp_type        rsp_ff, rsp_in;

   // Mark memory, one entry per processor and vector.
   logic [ivec_pkg::MARK_W-1:0]   marks_mem [ivec_pkg::MEM_DEPTH];

   logic                          best_found;
   logic [ivec_pkg::CPU_W-1:0]    least_cpu;
   logic [ivec_pkg::CNT_W-1:0]    best_load;
   logic [ivec_pkg::PTR_W-1:0]    scan_addr;
   logic                          scan_in_range;
   logic                          scan_issue;
   logic                          rd_en;
   logic [ivec_pkg::ADDR_W-1:0]   rd_addr;
   logic                          wr_en;
   logic [ivec_pkg::ADDR_W-1:0]   wr_addr;
   logic [ivec_pkg::MARK_W-1:0]   wr_data;
   logic                          op_ok;
   logic [ivec_pkg::MARK_W-1:0]   new_marks;
   logic                          is_reserve;
   logic                          out_free;
   logic                          rsp_load;

   // Flat memory address of one processor's table entry.
   function automatic logic [ivec_pkg::ADDR_W-1:0] mark_addr(
      input logic [ivec_pkg::CPU_W-1:0] cpu,
      input logic [ivec_pkg::VEC_W-1:0] vec
   );
      logic [ivec_pkg::ADDR_W-1:0] base;
      base = ivec_pkg::ADDR_W'(cpu) * ivec_pkg::ADDR_W'(ivec_pkg::NUM_VECTORS);
      return base + ivec_pkg::ADDR_W'(vec);
   endfunction

   assign csr_ready = 1'b1;

   // Configuration writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_vector_ff <= ivec_pkg::FIRST_VECTOR_RST;
         last_vector_ff  <= ivec_pkg::LAST_VECTOR_RST;
         cpu_enable_ff   <= ivec_pkg::CPU_ENABLE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ivec_pkg::CSR_FIRST_VECTOR: first_vector_ff <= csr_data;
            ivec_pkg::CSR_LAST_VECTOR:  last_vector_ff  <= csr_data;
            ivec_pkg::CSR_CPU_ENABLE:   cpu_enable_ff   <= csr_data[ivec_pkg::NUM_CPUS-1:0];
            default: ;
         endcase
      end
   end

   // Least-loaded enabled processor, ties to the lower index.
   always_comb begin
      best_found = 1'b0;
      least_cpu  = '0;
      best_load  = '0;
      for (int i = 0; i < ivec_pkg::NUM_CPUS; i++) begin
         if (cpu_enable_ff[i] && (!best_found || reserved_count_ff[i] < best_load)) begin
            best_found = 1'b1;
            least_cpu  = ivec_pkg::CPU_W'(i);
            best_load  = reserved_count_ff[i];
         end
      end
   end

   // Range scan: the start reads first_vector, each step reads the next pointer.
   assign scan_addr     = cmd.scan_start ? {1'b0, first_vector_ff} : scan_ptr_ff;
   assign scan_in_range = (scan_addr <= {1'b0, last_vector_ff}) &&
                          (scan_addr < ivec_pkg::PTR_W'(ivec_pkg::NUM_VECTORS));
   assign scan_issue    = (cmd.scan_start || cmd.scan_step) && scan_in_range;

   // Read port selection and tracking of the vector that the read data belongs to.
   always_comb begin
      rd_en       = 1'b0;
      rd_addr     = mark_addr(cpu_sel_ff, req_ff.vector);
      rd_vec_in   = rd_vec_ff;
      rd_valid_in = rd_valid_ff;
      scan_ptr_in = scan_ptr_ff;
      if (cmd.read_named) begin
         rd_en       = 1'b1;
         rd_vec_in   = req_ff.vector;
         rd_valid_in = 1'b1;
      end else if (cmd.scan_start || cmd.scan_step) begin
         rd_en       = scan_issue;
         rd_addr     = mark_addr(cpu_sel_ff, scan_addr[ivec_pkg::VEC_W-1:0]);
         rd_valid_in = scan_issue;
         scan_ptr_in = scan_addr + ivec_pkg::PTR_W'(1);
         if (scan_issue) begin
            rd_vec_in = scan_addr[ivec_pkg::VEC_W-1:0];
         end
      end
   end

   // Outcome of the operation on the entry just read.
   assign is_reserve = (req_ff.mode == ivec_pkg::MODE_RESERVE) ||
                       (req_ff.mode == ivec_pkg::MODE_LEAST);
   always_comb begin
      op_ok     = 1'b0;
      new_marks = mark_q_ff;
      case (req_ff.mode)
         ivec_pkg::MODE_RESERVE, ivec_pkg::MODE_LEAST: begin
            op_ok                       = !mark_q_ff[ivec_pkg::RSV_BIT];
            new_marks[ivec_pkg::RSV_BIT] = 1'b1;
         end
         ivec_pkg::MODE_UNRESERVE: begin
            op_ok                       = mark_q_ff[ivec_pkg::RSV_BIT];
            new_marks[ivec_pkg::RSV_BIT] = 1'b0;
         end
         ivec_pkg::MODE_CONNECT: begin
            op_ok                       = !mark_q_ff[ivec_pkg::CON_BIT];
            new_marks[ivec_pkg::CON_BIT] = 1'b1;
         end
         ivec_pkg::MODE_DISCONNECT: begin
            op_ok                       = mark_q_ff[ivec_pkg::CON_BIT];
            new_marks[ivec_pkg::CON_BIT] = 1'b0;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   // Write port: the clearing pass after reset, or the commit of an operation.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clear_ptr_ff;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.commit) begin
         wr_en   = 1'b1;
         wr_addr = mark_addr(cpu_sel_ff, rd_vec_ff);
         wr_data = new_marks;
      end
   end

   // Mark memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         marks_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mark_q_ff <= marks_mem[rd_addr];
      end
   end

   // Processor selection for the current request.
   always_comb begin
      cpu_sel_in = cpu_sel_ff;
      if (cmd.sel_best) begin
         cpu_sel_in = least_cpu;
      end else if (cmd.sel_req_cpu) begin
         cpu_sel_in = req_ff.cpu_index;
      end
   end

   // Result register; a new result may load while the old one is taken.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = cmd.commit || cmd.fail;
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (cmd.commit) begin
            rsp_in.ok         = 1'b1;
            rsp_in.cpu_out    = cpu_sel_ff;
            rsp_in.vector_out = rd_vec_ff;
         end else begin
            rsp_in = '0;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ptr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ivec_pkg::NUM_CPUS; i++) begin
            reserved_count_ff[i] <= '0;
         end
      end else begin
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear_step) begin
            clear_ptr_ff <= clear_ptr_ff + ivec_pkg::ADDR_W'(1);
         end
         if (cmd.commit) begin
            if (is_reserve) begin
               reserved_count_ff[cpu_sel_ff] <= reserved_count_ff[cpu_sel_ff] +
                                                ivec_pkg::CNT_W'(1);
            end else if (req_ff.mode == ivec_pkg::MODE_UNRESERVE) begin
               reserved_count_ff[cpu_sel_ff] <= reserved_count_ff[cpu_sel_ff] -
                                                ivec_pkg::CNT_W'(1);
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      cpu_sel_ff  <= cpu_sel_in;
      scan_ptr_ff <= scan_ptr_in;
      rd_vec_ff   <= rd_vec_in;
      rsp_ff      <= rsp_in;
   end

   // Status toward the controller.
   always_comb begin
      sts            = '0;
      sts.clear_last = (clear_ptr_ff == ivec_pkg::ADDR_W'(ivec_pkg::MEM_DEPTH - 1));
      sts.mode       = req_ff.mode;
      sts.any_vector = req_ff.any_vector;
      sts.cpu_valid  = (32'(req_ff.cpu_index) < ivec_pkg::NUM_CPUS);
      sts.vec_valid  = (32'(req_ff.vector) < ivec_pkg::NUM_VECTORS);
      sts.best_found = best_found;
      sts.rd_valid   = rd_valid_ff;
      sts.hit        = (mark_q_ff == '0);
      sts.op_ok      = op_ok;
      sts.out_free   = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result is only produced when the result register can take it.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded while the previous one is still held");

   // A commit is only issued for an operation that succeeds.
   a_commit_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> op_ok)
      else $error("commit issued for a failing operation");

   // A failed result carries no processor and no vector.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.fail |=> (!rsp_ff.ok && rsp_ff.cpu_out == '0 && rsp_ff.vector_out == '0))
      else $error("failure result with nonzero fields");

   // Memory is never written while a request is being sequenced through the scan.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_start || cmd.scan_step) |-> !wr_en)
      else $error("mark memory written during a vector scan");

endmodule

/* design/ivec_controller.sv */
// Controller state machine of the interrupt vector allocator.
// Sequences clearing, decode, table reads, vector scan and result; depends on ivec_pkg.
module ivec_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ivec_pkg::ivec_sts_type sts,
   output ivec_pkg::ivec_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_SCAN_START,
      ST_SCAN,
      ST_EXEC,
      ST_FAIL
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      to_reserve;

   // Next state and commands.
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      to_reserve = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FAIL;
            case (sts.mode)
               ivec_pkg::MODE_LEAST: begin
                  if (sts.best_found) begin
                     cmd.sel_best = 1'b1;
                     to_reserve   = 1'b1;
                  end
               end
               ivec_pkg::MODE_RESERVE: begin
                  if (sts.cpu_valid) begin
                     cmd.sel_req_cpu = 1'b1;
                     to_reserve      = 1'b1;
                  end
               end
               ivec_pkg::MODE_UNRESERVE, ivec_pkg::MODE_CONNECT,
               ivec_pkg::MODE_DISCONNECT: begin
                  if (sts.cpu_valid && !sts.any_vector && sts.vec_valid) begin
                     cmd.sel_req_cpu = 1'b1;
                     state_in        = ST_READ;
                  end
               end
               default: begin
                  state_in = ST_FAIL;
               end
            endcase
            // Reservation takes either the range scan or a named read.
            if (to_reserve) begin
               if (sts.any_vector) begin
                  state_in = ST_SCAN_START;
               end else if (sts.vec_valid) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.read_named = 1'b1;
            state_in       = ST_EXEC;
         end
         ST_SCAN_START: begin
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (!sts.rd_valid) begin
               state_in = ST_FAIL;
            end else if (sts.hit) begin
               state_in = ST_EXEC;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               cmd.commit = sts.op_ok;
               cmd.fail   = !sts.op_ok;
               state_in   = ST_IDLE;
            end
         end
         ST_FAIL: begin
            if (sts.out_free) begin
               cmd.fail = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and the registered stall toward the request side.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

   // The request side is open exactly in the idle state.
   a_stall_idle: assert property (@(posedge clock) disable iff (reset)
      req_stall_ff == (state_ff != ST_IDLE))
      else $error("request stall out of step with the state");

   // Every accepted request leaves idle for decode.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded");

   // A result is produced only on the way back to idle.
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.fail) |=> state_ff == ST_IDLE)
      else $error("result produced without returning to idle");

endmodule

/* design/irq_vector_allocator.sv */
// Interrupt vector allocator; built from ivec_pkg, ivec_controller and ivec_datapath.
// Each request passes decode, then a named table read or a range scan up to the first free
// entry, then the result; a request rejected at decode or a scan with no free entry in range
// yields a failure result. A stalled result delays the next one.
// Throughput: one request at a time, the next taken in the cycle after its result loads.
// Synchronous reset; a pass then clears all 1024 mark memory entries before any request.
module irq_vector_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ivec_pkg::ivec_req_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ivec_pkg::ivec_rsp_type          rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ivec_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ivec_pkg::CSR_DATA_W-1:0] csr_data
);

   ivec_pkg::ivec_cmd_type cmd;
   ivec_pkg::ivec_sts_type sts;

   // Sequencing of each request.
   ivec_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Tables, counters, configuration and the result register.
   ivec_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
